// ===== design/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   // Most code units that one input byte can cause.
   localparam int MaxUnits = 4;

   localparam logic [15:0] REPL_UNIT      = 16'h003F;
   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
   localparam logic [20:0] SCALAR_MAX     = 21'h10FFFF;
   localparam logic [20:0] SUPP_BASE      = 21'h010000;
   localparam logic [20:0] SURR_FIRST     = 21'h00D800;
   localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
   localparam logic [20:0] MIN_TWO_BYTE   = 21'h000080;
   localparam logic [20:0] MIN_THREE_BYTE = 21'h000800;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_last;
   } u8u16_req_type;

   typedef struct packed {
      logic [15:0] utf16_unit;
      logic        run_last;
      logic        string_done;
   } u8u16_rsp_type;

   // All units caused by one input byte, oldest in entry 0.
   typedef struct packed {
      logic [MaxUnits-1:0][15:0] units;
      logic [2:0]                unit_count;
      logic                      string_end;
   } u8u16_bundle_type;

endpackage

// ===== design/u8u16_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts bytes, keeps the partial sequence and decodes each byte into a
// bundle of up to four UTF-16 code units.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  u8u16_pkg::u8u16_req_type   req_data,
   output logic                       req_full,
   input  logic                       queue_full,
   output logic                       queue_push,
   output u8u16_pkg::u8u16_bundle_type queue_data
);
   import u8u16_pkg::*;

   logic [2:0][7:0] held_bytes_ff, held_bytes_in;
   logic [1:0]      held_count_ff, held_count_in;

   logic            accept;
   logic [3:0][7:0] q;
   logic [2:0]      n;
   logic [2:0]      pos;
   logic [2:0]      need;
   logic [7:0]      lead;
   logic [7:0]      cont;
   logic [20:0]     value;
   logic [20:0]     supp;
   logic            bad;
   logic            done;
   logic            hold;
   logic [2:0]      nu;
   logic [3:0][15:0] units;
   logic [1:0]      hold_count;
   logic [2:0][7:0] hold_bytes;
   logic [15:0]     unit_val;
   logic            unit_ok;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b[7] == 1'b0) len = 3'd1;
      else if (b[7:5] == 3'b110) len = 3'd2;
      else if (b[7:4] == 4'b1110) len = 3'd3;
      else if (b[7:3] == 5'b11110) len = 3'd4;
      return len;
   endfunction

   assign accept   = req_push && !queue_full;
   assign req_full = queue_full;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (k < int'(held_count_ff)) q[k] = held_bytes_ff[k];
         else if (k == int'(held_count_ff)) q[k] = req_data.in_byte;
         else q[k] = 8'h00;
      end
      n          = {1'b0, held_count_ff} + 3'd1;
      pos        = 3'd0;
      nu         = 3'd0;
      units      = '0;
      done       = 1'b0;
      hold       = 1'b0;
      hold_count = 2'd0;
      hold_bytes = held_bytes_ff;
      lead       = 8'h00;
      need       = 3'd0;
      cont       = 8'h00;
      value      = '0;
      supp       = '0;
      bad        = 1'b0;
      unit_val   = REPL_UNIT;
      unit_ok    = 1'b0;

      // Each step consumes at least one byte, so four steps cover the queue.
      for (int s = 0; s < 4; s++) begin
         if (!done && pos < n) begin
            lead = q[pos[1:0]];
            need = lead_length(lead);
            unit_ok = 1'b0;
            if (need == 3'd1) begin
               unit_val = {8'h00, lead};
               unit_ok  = 1'b1;
               pos      = pos + 3'd1;
            end else if (need == 3'd0) begin
               unit_val = REPL_UNIT;
               unit_ok  = 1'b1;
               pos      = pos + 3'd1;
            end else if (({1'b0, pos} + {1'b0, need}) > {1'b0, n}) begin
               // Sequence not complete yet: hold it, or replace it at string end.
               done = 1'b1;
               if (req_data.string_last) begin
                  unit_val = REPL_UNIT;
                  unit_ok  = 1'b1;
               end else begin
                  hold       = 1'b1;
                  hold_count = 2'(n - pos);
                  for (int k = 0; k < 3; k++) begin
                     if (k < int'(hold_count)) hold_bytes[k] = q[2'(int'(pos) + k)];
                  end
               end
            end else begin
               if (need == 3'd2) value = {16'h0000, lead[4:0]};
               else if (need == 3'd3) value = {17'h00000, lead[3:0]};
               else value = {18'h00000, lead[2:0]};
               bad = 1'b0;
               for (int k = 1; k < 4; k++) begin
                  if (k < int'(need) && !bad) begin
                     cont = q[2'(int'(pos) + k)];
                     if (cont[7:6] != 2'b10) bad = 1'b1;
                     else value = {value[14:0], cont[5:0]};
                  end
               end
               if (bad) begin
                  // Only the lead is replaced; the next byte is decoded afresh.
                  unit_val = REPL_UNIT;
                  unit_ok  = 1'b1;
                  pos      = pos + 3'd1;
               end else begin
                  pos = pos + need;
                  if ((need == 3'd2 && value < MIN_TWO_BYTE) ||
                      (need == 3'd3 && value < MIN_THREE_BYTE) ||
                      (need == 3'd4 && value < SUPP_BASE) ||
                      value > SCALAR_MAX ||
                      (value >= SURR_FIRST && value <= SURR_LAST)) begin
                     unit_val = REPL_UNIT;
                     unit_ok  = 1'b1;
                  end else if (value < SUPP_BASE) begin
                     unit_val = value[15:0];
                     unit_ok  = 1'b1;
                  end else begin
                     supp = value - SUPP_BASE;
                     if (nu < 3'd4) begin
                        units[nu[1:0]] = HIGH_SURR_BASE | {6'h00, supp[19:10]};
                        nu = nu + 3'd1;
                     end
                     unit_val = LOW_SURR_BASE | {6'h00, supp[9:0]};
                     unit_ok  = 1'b1;
                  end
               end
            end
            if (unit_ok && nu < 3'd4) begin
               units[nu[1:0]] = unit_val;
               nu = nu + 3'd1;
            end
         end
      end

      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      if (accept) begin
         if (hold) begin
            held_bytes_in = hold_bytes;
            held_count_in = hold_count;
         end else begin
            held_count_in = 2'd0;
         end
      end
   end

   assign queue_push            = accept && (nu != 3'd0);
   assign queue_data.units      = units;
   assign queue_data.unit_count = nu;
   assign queue_data.string_end = req_data.string_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
      end else begin
         held_count_ff <= held_count_in;
      end
   end

   always_ff @(posedge clock) begin
      held_bytes_ff <= held_bytes_in;
   end

endmodule

// ===== design/u8u16_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_queue
// Short first-in first-out queue of decoded unit bundles.
// ----------------------------------------------------------------------------
module u8u16_queue #(
   parameter int DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  u8u16_pkg::u8u16_bundle_type push_data,
   output logic                        full,
   input  logic                        pop,
   output u8u16_pkg::u8u16_bundle_type pop_data,
   output logic                        empty
);
   import u8u16_pkg::*;

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   u8u16_bundle_type          mem_ff [DEPTH];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]       count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == FullCnt);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== design/u8u16_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_back
// Holds one bundle and hands its code units out one transaction at a time.
// ----------------------------------------------------------------------------
module u8u16_back (
   input  logic                        clock,
   input  logic                        reset,
   input  u8u16_pkg::u8u16_bundle_type queue_data,
   input  logic                        queue_empty,
   output logic                        queue_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output u8u16_pkg::u8u16_rsp_type    rsp_data
);
   import u8u16_pkg::*;

   u8u16_bundle_type cur_ff, cur_in;
   logic [1:0]       idx_ff, idx_in;
   logic             busy_ff, busy_in;
   logic             taken;
   logic             last_unit;
   logic             reload;

   assign last_unit = ({1'b0, idx_ff} + 3'd1) == cur_ff.unit_count;
   assign taken     = rsp_pop && busy_ff;
   assign reload    = !busy_ff || (taken && last_unit);
   assign queue_pop = reload && !queue_empty;

   assign rsp_empty            = !busy_ff;
   assign rsp_data.utf16_unit  = cur_ff.units[idx_ff];
   assign rsp_data.run_last    = last_unit;
   assign rsp_data.string_done = last_unit && cur_ff.string_end;

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (reload) begin
         // The next bundle follows the last unit without a gap cycle.
         busy_in = !queue_empty;
         idx_in  = 2'd0;
         if (!queue_empty) cur_in = queue_data;
      end else if (taken) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ===== design/utf8_to_utf16_transcoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Streaming UTF-8 to UTF-16 transcoder with queue-style ports on both sides.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per transaction and can accept a byte in
// every cycle with req_full low. Each byte is decoded on arrival: it either
// completes a sequence and yields its code units, or it is held (up to three
// bytes) until the sequence completes or the string ends. Valid scalars above
// 0xFFFF become a surrogate pair; overlong forms, surrogate values, values
// above 0x10FFFF, bad lead bytes and sequences cut off by the end of the
// string yield a single '?' (0x003F). A bad continuation byte replaces only
// the lead with '?' and the following bytes are decoded again from scratch.
// A front stage decodes a byte combinationally into a bundle of up to four
// units, a short queue of FIFO_DEPTH bundles follows, and a back stage hands
// the units out one per cycle while rsp_pop takes them. The output serializer
// sets the sustained rate: one unit per cycle while rsp_pop is high, so a
// byte takes one result slot per unit that it yields, and bytes that yield
// none (the first bytes of a multibyte sequence) take no result slot at all.
// When the result side is idle, the first unit of a byte is registered in
// the queue and then in the back stage. On every result transaction run_last
// marks the last unit that its byte caused and string_done marks the final
// unit of the string; after the final byte all held state is cleared.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core #(
   parameter int FIFO_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  u8u16_pkg::u8u16_req_type req_data,
   output logic                     req_full,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output u8u16_pkg::u8u16_rsp_type rsp_data
);
   import u8u16_pkg::*;

   u8u16_bundle_type push_bundle;
   u8u16_bundle_type head_bundle;
   logic             queue_push;
   logic             queue_pop;
   logic             queue_full;
   logic             queue_empty;

   // Front: accepts bytes, keeps the partial sequence, decodes into bundles.
   u8u16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (push_bundle)
   );

   // Queue that lets the decoder run ahead while units are still draining.
   u8u16_queue #(
      .DEPTH (FIFO_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_bundle),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (head_bundle),
      .empty     (queue_empty)
   );

   // Back: serializes each bundle onto the result port.
   u8u16_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_data  (head_bundle),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule
